// ----- rtl/ibt_pkg.sv -----
// Shared types and constants for the interval booking table.
// No dependencies; used by every module of the block.
`default_nettype none

package ibt_pkg;

    localparam int MAX_BOOKINGS = 64;
    localparam int TIME_BITS    = 32;

    // Port widths are fixed; stored times keep only the bits that matter.
    localparam int PORT_TIME_W = 32;
    localparam int TW          = (TIME_BITS < PORT_TIME_W) ? TIME_BITS : PORT_TIME_W;
    localparam int AW          = (MAX_BOOKINGS > 1) ? $clog2(MAX_BOOKINGS) : 1;
    localparam int CW          = $clog2(MAX_BOOKINGS + 1);
    localparam int BC_W        = 7;
    localparam int ST_W        = 2;

    localparam logic [ST_W-1:0] ST_BOOKED  = 2'd0;
    localparam logic [ST_W-1:0] ST_OVERLAP = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic [TW-1:0] t_start;
        logic [TW-1:0] t_end;
    } entry_t;

    typedef struct packed {
        logic          wr_en;
        logic [AW-1:0] wr_addr;
        logic          rd_en;
        logic [AW-1:0] rd_addr;
    } mem_req_t;

endpackage

`default_nettype wire

// ----- rtl/ibt_mem.sv -----
// Interval storage: one write port, one read port with registered data.
// Depends on ibt_pkg.
`default_nettype none

module ibt_mem (
    input  wire logic              clk,
    input  wire ibt_pkg::mem_req_t req,
    input  wire ibt_pkg::entry_t   wr_data,
    output ibt_pkg::entry_t        rd_data
);

    ibt_pkg::entry_t mem [ibt_pkg::MAX_BOOKINGS];
    ibt_pkg::entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ----- rtl/ibt_ovl.sv -----
// Shared overlap comparator: max(starts) < min(ends) on half-open intervals.
// Depends on ibt_pkg.
`default_nettype none

module ibt_ovl (
    input  wire ibt_pkg::entry_t stored,
    input  wire ibt_pkg::entry_t request,
    output logic                 hit
);

    logic [ibt_pkg::TW-1:0] hi_start;
    logic [ibt_pkg::TW-1:0] lo_end;

    always_comb
    begin
        hi_start = (stored.t_start > request.t_start) ? stored.t_start : request.t_start;
        lo_end   = (stored.t_end < request.t_end) ? stored.t_end : request.t_end;
        hit      = hi_start < lo_end;
    end

endmodule

`default_nettype wire

// ----- rtl/interval_booking_table.sv -----
// Top level of the interval booking table: sequencer, count and result register.
// Depends on ibt_pkg, ibt_mem and ibt_ovl.
//
// Usage:
//   The input channel (in_valid/in_ready) carries one request word: start_time
//   and end_time of a half-open interval [start, end). The output channel
//   (out_valid/out_ready) returns one word per request: status (booked,
//   overlap, full) and booked_count, the number of stored intervals after it.
//   A request scans the stored entries one per cycle through a single memory
//   read port and one shared overlap comparator. A request passes through the
//   accept step, one read per stored entry, a drain step for the registered
//   read data and the decide step; with an empty table the sequencer goes
//   from accept straight to the decide step, skipping the reads and the drain.
//   in_ready is high only while the sequencer is idle, one request at a time.
//   A finished result sits in the output register; the next request is
//   accepted while it waits. If the receiver still stalls when the following
//   result is ready, the sequencer holds in its decide step until the output
//   register frees up.
//   Reset clears the entry count and all control state; the memory contents
//   are not cleared, since only entries below the count are ever read.
`default_nettype none

module interval_booking_table (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_ready,
    input  wire logic [ibt_pkg::PORT_TIME_W-1:0]     start_time,
    input  wire logic [ibt_pkg::PORT_TIME_W-1:0]     end_time,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [ibt_pkg::ST_W-1:0]                 status,
    output logic [ibt_pkg::BC_W-1:0]                 booked_count
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DRAIN  = 2'd2;
    localparam logic [1:0] S_DECIDE = 2'd3;

    logic [1:0]                 state_reg, state_next;
    logic [ibt_pkg::AW-1:0]     idx_reg, idx_next;
    logic [ibt_pkg::CW-1:0]     count_reg, count_next;
    logic                       pend_reg, pend_next;
    logic                       hit_reg, hit_next;
    ibt_pkg::entry_t            req_reg, req_next;
    logic                       out_valid_reg, out_valid_next;
    logic [ibt_pkg::ST_W-1:0]   status_reg, status_next;
    logic [ibt_pkg::BC_W-1:0]   bc_reg, bc_next;

    ibt_pkg::mem_req_t          mem_req;
    ibt_pkg::entry_t            rd_data;
    logic                       ovl_hit;

    ibt_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .wr_data (req_reg),
        .rd_data (rd_data)
    );

    ibt_ovl u_ovl (
        .stored  (rd_data),
        .request (req_reg),
        .hit     (ovl_hit)
    );

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        req_next       = req_reg;
        status_next    = status_reg;
        bc_next        = bc_reg;
        out_valid_next = out_valid_reg;
        pend_next      = 1'b0;
        // Fold in the compare of the entry read last cycle.
        hit_next       = hit_reg | (pend_reg & ovl_hit);

        mem_req.wr_en   = 1'b0;
        mem_req.wr_addr = count_reg[ibt_pkg::AW-1:0];
        mem_req.rd_en   = 1'b0;
        mem_req.rd_addr = idx_reg;

        // Drop the result once the receiver takes it.
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next.t_start = start_time[ibt_pkg::TW-1:0];
                    req_next.t_end   = end_time[ibt_pkg::TW-1:0];
                    hit_next         = 1'b0;
                    idx_next         = '0;
                    state_next       = (count_reg == '0) ? S_DECIDE : S_SCAN;
                end
            end
            S_SCAN:
            begin
                // Issue one read per cycle; the compare follows once the read data is registered.
                mem_req.rd_en = 1'b1;
                pend_next     = 1'b1;
                if (ibt_pkg::CW'(idx_reg) == count_reg - ibt_pkg::CW'(1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + ibt_pkg::AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                // Hold until the output register is free.
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    if (hit_reg)
                    begin
                        status_next = ibt_pkg::ST_OVERLAP;
                        bc_next     = ibt_pkg::BC_W'(count_reg);
                    end
                    else if (count_reg >= ibt_pkg::CW'(ibt_pkg::MAX_BOOKINGS))
                    begin
                        status_next = ibt_pkg::ST_FULL;
                        bc_next     = ibt_pkg::BC_W'(count_reg);
                    end
                    else
                    begin
                        mem_req.wr_en = 1'b1;
                        count_next    = count_reg + ibt_pkg::CW'(1);
                        status_next   = ibt_pkg::ST_BOOKED;
                        bc_next       = ibt_pkg::BC_W'(count_reg + ibt_pkg::CW'(1));
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            count_reg     <= '0;
            pend_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            count_reg     <= count_next;
            pend_reg      <= pend_next;
            hit_reg       <= hit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        status_reg <= status_next;
        bc_reg     <= bc_next;
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign booked_count = bc_reg;

    // A new result only appears out of the decide step.
    a_result_from_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DECIDE)
        else $error("result raised outside decide step");

    // The count moves only together with a booked result.
    a_count_with_booked: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (out_valid_reg && status_reg == ibt_pkg::ST_BOOKED))
        else $error("entry count changed without a booked result");

    // The table never grows past its capacity.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DECIDE) |-> (count_reg <= ibt_pkg::CW'(ibt_pkg::MAX_BOOKINGS)))
        else $error("entry count beyond capacity");

    // After accepting a request the block is not ready in the next cycle.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("ready held across an accepted request");

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Self-checking testbench for interval_booking_table: directed and random booking requests.
// Depends on ibt_pkg and the interval_booking_table RTL; predicts every reply on its own.
`default_nettype none

module testbench;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int TAIL_CYCLES   = 80;
    localparam int MAX_REPORTED  = 10;

    typedef struct packed {
        logic [ibt_pkg::ST_W-1:0] status;
        logic [ibt_pkg::BC_W-1:0] booked;
    } booking_reply_t;

    typedef enum int {
        PICK_OVERLAP,
        PICK_TOUCH,
        PICK_FRESH,
        PICK_EMPTY,
        PICK_NOISE
    } request_kind_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [ibt_pkg::PORT_TIME_W-1:0] start_time = '0;
    logic [ibt_pkg::PORT_TIME_W-1:0] end_time = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic [ibt_pkg::ST_W-1:0]        status;
    logic [ibt_pkg::BC_W-1:0]        booked_count;

    // Own copy of the booking table, advanced once per accepted request word.
    logic [ibt_pkg::TW-1:0]  held_start [ibt_pkg::MAX_BOOKINGS];
    logic [ibt_pkg::TW-1:0]  held_end   [ibt_pkg::MAX_BOOKINGS];
    int                      held_count = 0;

    booking_reply_t          expected_replies [$];
    int                      mismatch_count = 0;
    int                      cycle_count = 0;
    int                      stall_left = 0;
    bit                      quiet_stretch = 1'b0;
    logic [ibt_pkg::TW-1:0]  fresh_cursor = 32'h4000_0000;

    interval_booking_table dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .start_time   (start_time),
        .end_time     (end_time),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .booked_count (booked_count)
    );

    always #6 clk = ~clk;

    // Decide one request against the held table and book it when it fits.
    // Overlap of half-open intervals: the later start lies before the earlier end.
    // A conflict wins over a full table; any rejection leaves the count unchanged.
    function automatic booking_reply_t book_interval(
        input logic [ibt_pkg::PORT_TIME_W-1:0] s,
        input logic [ibt_pkg::PORT_TIME_W-1:0] e);
        booking_reply_t          reply;
        logic [ibt_pkg::TW-1:0]  s_t;
        logic [ibt_pkg::TW-1:0]  e_t;
        logic [ibt_pkg::TW-1:0]  later_start;
        logic [ibt_pkg::TW-1:0]  earlier_end;
        logic                    hit;
        s_t = s[ibt_pkg::TW-1:0];
        e_t = e[ibt_pkg::TW-1:0];
        hit = 1'b0;
        for (int i = 0; i < held_count; i++)
        begin
            later_start = (held_start[i] > s_t) ? held_start[i] : s_t;
            earlier_end = (held_end[i] < e_t) ? held_end[i] : e_t;
            if (later_start < earlier_end)
                hit = 1'b1;
        end
        if (hit)
        begin
            reply.status = ibt_pkg::ST_OVERLAP;
        end
        else if (held_count >= ibt_pkg::MAX_BOOKINGS)
        begin
            reply.status = ibt_pkg::ST_FULL;
        end
        else
        begin
            reply.status = ibt_pkg::ST_BOOKED;
            held_start[held_count] = s_t;
            held_end[held_count] = e_t;
            held_count++;
        end
        reply.booked = held_count[ibt_pkg::BC_W-1:0];
        return reply;
    endfunction

    // Present one request word and hold it until the block takes it.
    // Drop valid only around an idle gap so it never falls and rises in one step.
    task automatic send_request(input logic [ibt_pkg::PORT_TIME_W-1:0] s,
                                input logic [ibt_pkg::PORT_TIME_W-1:0] e);
        int             gap;
        booking_reply_t reply;
        if (!quiet_stretch && $urandom_range(0, 99) < 9)
        begin
            in_valid <= 1'b0;
            // Vary the gap widely so the next word lands on any phase of the scan.
            gap = $urandom_range(1, 70);
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        start_time <= s;
        end_time   <= e;
        do
            @(posedge clk);
        while (!in_ready);
        reply = book_interval(s, e);
        expected_replies = {expected_replies, reply};
    endtask

    // Lower valid and hold off until every outstanding reply has come back.
    task automatic wait_for_replies();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_replies.size() != 0);
    endtask

    // Pick one request of the given kind, aimed at the current table contents.
    task automatic send_kind(input request_kind_t kind);
        logic [ibt_pkg::TW-1:0] s;
        logic [ibt_pkg::TW-1:0] e;
        logic [ibt_pkg::TW-1:0] span;
        int                     j;
        request_kind_t          k;
        k = kind;
        if (held_count == 0 && (k == PICK_OVERLAP || k == PICK_TOUCH))
            k = PICK_FRESH;
        j = (held_count > 0) ? $urandom_range(0, held_count - 1) : 0;
        case (k)
            PICK_OVERLAP:
            begin
                // Land inside a proper stored interval; empty ones get a random span.
                if (held_start[j] < held_end[j])
                begin
                    span = held_end[j] - held_start[j];
                    s = held_start[j] + ($urandom % span);
                    e = s + 1 + $urandom_range(0, 1000);
                    if ($urandom_range(0, 3) == 0)
                        s = s - $urandom_range(0, 1000);
                end
                else
                begin
                    s = held_end[j] - $urandom_range(0, 500);
                    e = held_start[j] + $urandom_range(1, 500);
                end
            end
            PICK_TOUCH:
            begin
                if ($urandom_range(0, 1) == 0)
                begin
                    s = held_end[j];
                    e = s + $urandom_range(1, 800);
                end
                else
                begin
                    e = held_start[j];
                    s = e - $urandom_range(1, 800);
                end
            end
            PICK_FRESH:
            begin
                fresh_cursor = fresh_cursor + $urandom_range(0, 1000);
                s = fresh_cursor;
                fresh_cursor = fresh_cursor + $urandom_range(1, 1000);
                e = fresh_cursor;
            end
            PICK_EMPTY:
            begin
                // Empty or inverted: never conflicts, so it books or reports full.
                s = $urandom;
                e = ($urandom_range(0, 1) == 0) ? s : s - $urandom_range(1, 5000);
            end
            default:
            begin
                s = $urandom;
                e = $urandom;
                case ($urandom_range(0, 7))
                    0: s = '0;
                    1: e = '1;
                    2: e = s + $urandom_range(1, 100000);
                    default: ;
                endcase
            end
        endcase
        send_request(s, e);
    endtask

    // Weighted mix: mostly aimed requests, some noise.
    task automatic send_mixed_request();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35)
            send_kind(PICK_OVERLAP);
        else if (roll < 50)
            send_kind(PICK_TOUCH);
        else if (roll < 65)
            send_kind(PICK_FRESH);
        else if (roll < 73)
            send_kind(PICK_EMPTY);
        else
            send_kind(PICK_NOISE);
    endtask

    // Empty table, touching neighbors, overlaps, empty and inverted requests.
    task automatic test_touching_and_empty();
        send_request(32'd0, 32'd1);
        send_request(32'd1, 32'd2);
        send_request(32'd0, 32'd2);
        send_request(32'd5, 32'd5);
        send_request(32'd10, 32'd3);
        send_request(32'd3, 32'd3);
        send_request(32'd2, 32'd3);
        send_request(32'd1, 32'd3);
        send_request(32'd4, 32'd6);
        send_request(32'd3, 32'd4);
    endtask

    // Times at the ends of the range, with every bit set and clear.
    task automatic test_time_extremes();
        send_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'h0000_0000);
        send_request(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFD, 32'hFFFF_FFFE);
        send_request(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_request(32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        send_request(32'h6000_0000, 32'h6000_0001);
        wait_for_replies();
    endtask

    // Random traffic while the table fills, with a stretch of no idling on either side.
    task automatic test_random_traffic(input int count);
        for (int n = 0; n < count; n++)
        begin
            quiet_stretch = (n >= 150 && n < 230);
            send_mixed_request();
        end
        quiet_stretch = 1'b0;
    endtask

    // Fill the table, then hit it with conflicting and non-conflicting requests.
    task automatic test_full_table(input int count);
        int attempt;
        wait_for_replies();
        attempt = 0;
        while (held_count < ibt_pkg::MAX_BOOKINGS)
        begin
            // Every fourth attempt is an empty interval, which always books.
            if (attempt % 4 == 3)
                send_kind(PICK_EMPTY);
            else
                send_kind(PICK_FRESH);
            attempt++;
        end
        for (int n = 0; n < count; n++)
        begin
            if (n % 5 == 0)
                send_kind(PICK_EMPTY);
            else
                send_mixed_request();
        end
    endtask

    // Check each reply word against the oldest expectation; drive the stall pattern.
    always @(posedge clk)
    begin
        booking_reply_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_replies.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                        $display("unexpected reply: status %0d booked_count %0d",
                                 status, booked_count);
                end
                else
                begin
                    want = expected_replies.pop_front();
                    if (status !== want.status || booked_count !== want.booked)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTED)
                            $display({"reply mismatch: status exp %0d act %0d, ",
                                      "booked_count exp %0d act %0d"},
                                     want.status, status, want.booked, booked_count);
                    end
                end
            end
            // Mostly short stalls, now and then a long one to back up the output register.
            if (stall_left > 0)
            begin
                stall_left--;
                out_ready <= 1'b0;
            end
            else if (!quiet_stretch && $urandom_range(0, 99) == 0)
            begin
                stall_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60)
                                                         : $urandom_range(1, 5);
                stall_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_touching_and_empty();
        test_time_extremes();
        test_random_traffic(300);
        test_full_table(120);

        // Drain: wait out every reply, then a tail for stray words.
        in_valid <= 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_replies.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

`default_nettype wire
